// ===== rtl/core/section_cycle_profiler_defines.svh =====
// Assertion helpers used by the checker of the profiler.
`ifndef SECTION_CYCLE_PROFILER_DEFINES_SVH
`define SECTION_CYCLE_PROFILER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/scp_pkg.sv =====
package scp_pkg;

   localparam int SECTION_COUNT_DEF = 8;
   localparam int SUM_W             = 64;
   localparam int WORD_W            = 32;
   localparam int SECTION_W         = 3;
   localparam int SHARE_W           = 10;
   localparam int PERIOD_W          = 16;
   localparam int PADDR_W           = 3;
   localparam int PDATA_W           = 32;

   localparam logic [PERIOD_W-1:0] REPORT_PERIOD_RESET = 16'd500;
   localparam logic [SHARE_W-1:0]  SHARE_MAX           = 10'd1000;

   // Word index of the report period register on the configuration port.
   localparam logic CSR_REPORT_PERIOD = 1'b0;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear_all;
   } scp_mem_ctl_type;

endpackage

// ===== rtl/core/scp_stat_mem.sv =====
module scp_stat_mem #(
   parameter int SECTION_COUNT = scp_pkg::SECTION_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  scp_pkg::scp_mem_ctl_type           ctl,
   input  logic [$clog2(SECTION_COUNT)-1:0]   rd_addr,
   input  logic [$clog2(SECTION_COUNT)-1:0]   wr_addr,
   input  logic [scp_pkg::SUM_W-1:0]          wr_sum,
   input  logic [scp_pkg::WORD_W-1:0]         wr_worst,
   output logic [scp_pkg::SUM_W-1:0]          rd_sum,
   output logic [scp_pkg::WORD_W-1:0]         rd_worst
);
   import scp_pkg::*;

   logic [SUM_W-1:0]         sum_mem_ff   [SECTION_COUNT];
   logic [WORD_W-1:0]        worst_mem_ff [SECTION_COUNT];
   logic [SECTION_COUNT-1:0] valid_ff;
   logic [SUM_W-1:0]         rd_sum_ff;
   logic [WORD_W-1:0]        rd_worst_ff;

   // An entry that has not been written since the last clear reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clear_all) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         sum_mem_ff[wr_addr]   <= wr_sum;
         worst_mem_ff[wr_addr] <= wr_worst;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_sum_ff   <= valid_ff[rd_addr] ? sum_mem_ff[rd_addr] : '0;
         rd_worst_ff <= valid_ff[rd_addr] ? worst_mem_ff[rd_addr] : '0;
      end
   end

   assign rd_sum   = rd_sum_ff;
   assign rd_worst = rd_worst_ff;

endmodule

// ===== rtl/core/scp_div.sv =====
module scp_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [scp_pkg::SUM_W-1:0] dividend,
   input  logic [scp_pkg::SUM_W-1:0] divisor,
   output logic                      done,
   output logic [scp_pkg::SUM_W-1:0] quotient
);
   import scp_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [SUM_W-1:0] quo_ff;
   logic [SUM_W-1:0] rem_ff;
   logic [SUM_W-1:0] divisor_ff;
   logic [SUM_W:0]   trial;
   logic [SUM_W:0]   diff;
   logic             fits;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = ~diff[SUM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/section_cycle_profiler.sv =====
// Section cycle profiler.
// The request channel takes one event per transaction: a section mark (mode 0)
// or an end of loop pass (mode 1), each with a cycle stamp and a millisecond
// time. The response channel carries report transactions: one summary followed
// by one transaction per section, the final one flagged with last.
// A mark passes through ST_CHARGE and an end of pass through ST_CHARGE and
// ST_PASS; the block holds req_stall high meanwhile. When an end of pass
// closes a report window, the report sequencer runs the 2 + 2*SECTION_COUNT
// divisions, all on a single one-bit-per-cycle divider; a division by zero is
// skipped. Each report transaction sits in an output register; while
// rsp_stall is high the sequencer waits at that transaction and the report
// simply takes longer. The last report transaction may still wait there
// while the next request is taken. Synchronous reset clears all statistics,
// selects the last section as active, sets the report period to 500 ms and
// drops rsp_valid. The report period register is written over the csr port;
// the user must write it only while the block is idle, and the block itself
// does not enforce this.
module section_cycle_profiler #(
   parameter int SECTION_COUNT = scp_pkg::SECTION_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [scp_pkg::WORD_W-1:0]    req_cycle_stamp,
   input  logic [scp_pkg::SECTION_W-1:0] req_section,
   input  logic [scp_pkg::WORD_W-1:0]    req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_section,
   output logic [scp_pkg::SECTION_W-1:0] rsp_section_index,
   output logic [scp_pkg::WORD_W-1:0]    rsp_passes,
   output logic [scp_pkg::WORD_W-1:0]    rsp_passes_per_ms,
   output logic [scp_pkg::WORD_W-1:0]    rsp_average_cycles,
   output logic [scp_pkg::WORD_W-1:0]    rsp_worst_cycles,
   output logic [scp_pkg::SHARE_W-1:0]   rsp_share_per_mille,
   output logic                          rsp_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [scp_pkg::PADDR_W-1:0]   csr_paddr,
   input  logic [scp_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic [scp_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import scp_pkg::*;

   localparam int IDX_W = $clog2(SECTION_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SECTION_COUNT - 1);

   typedef enum logic [13:0] {
      ST_IDLE        = 14'b00000000000001,
      ST_CHARGE      = 14'b00000000000010,
      ST_PASS        = 14'b00000000000100,
      ST_SUM_RD      = 14'b00000000001000,
      ST_SUM_ACC     = 14'b00000000010000,
      ST_PPM_DIV     = 14'b00000000100000,
      ST_AVG_DIV     = 14'b00000001000000,
      ST_EMIT_SUM    = 14'b00000010000000,
      ST_SEC_RD      = 14'b00000100000000,
      ST_MUL_A       = 14'b00001000000000,
      ST_MUL_B       = 14'b00010000000000,
      ST_SHARE_DIV   = 14'b00100000000000,
      ST_SEC_AVG_DIV = 14'b01000000000000,
      ST_EMIT_SEC    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic                started_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    active_ff;
   logic [WORD_W-1:0]   prev_mark_ff;
   logic [WORD_W-1:0]   pass_begin_ff;
   logic [WORD_W-1:0]   pass_total_ff;
   logic [WORD_W-1:0]   worst_pass_ff;
   logic [WORD_W-1:0]   prev_report_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic                rsp_valid_ff;

   logic                mode_ff;
   logic [WORD_W-1:0]   stamp_ff;
   logic [WORD_W-1:0]   now_ff;
   logic [IDX_W-1:0]    next_sec_ff;
   logic [WORD_W-1:0]   span_ff;
   logic [WORD_W-1:0]   window_ff;
   logic [SUM_W-1:0]    total_ff;
   logic [WORD_W-1:0]   ppm_ff;
   logic [WORD_W-1:0]   avg_ff;
   logic [SHARE_W-1:0]  share_ff;
   logic [SUM_W-1:0]    sec_sum_ff;
   logic [WORD_W-1:0]   sec_worst_ff;
   logic [SUM_W-1:0]    prod_ff;

   logic                rsp_is_section_ff;
   logic [SECTION_W-1:0] rsp_section_index_ff;
   logic [WORD_W-1:0]   rsp_passes_ff;
   logic [WORD_W-1:0]   rsp_passes_per_ms_ff;
   logic [WORD_W-1:0]   rsp_average_cycles_ff;
   logic [WORD_W-1:0]   rsp_worst_cycles_ff;
   logic [SHARE_W-1:0]  rsp_share_per_mille_ff;
   logic                rsp_last_ff;

   logic                req_accept;
   logic                out_free;
   logic                emit_load;
   logic                csr_wr_en;
   logic [IDX_W-1:0]    req_next_sec;
   logic [WORD_W-1:0]   pass_len;
   logic [WORD_W-1:0]   window;
   logic                window_short;

   scp_mem_ctl_type     mem_ctl;
   logic [IDX_W-1:0]    mem_rd_addr;
   logic [SUM_W-1:0]    mem_wr_sum;
   logic [WORD_W-1:0]   mem_wr_worst;
   logic [SUM_W-1:0]    mem_rd_sum;
   logic [WORD_W-1:0]   mem_rd_worst;

   logic                div_state;
   logic                div_skip;
   logic                div_start;
   logic                div_finish;
   logic [SUM_W-1:0]    div_dividend;
   logic [SUM_W-1:0]    div_divisor;
   logic                div_done;
   logic [SUM_W-1:0]    div_quotient;

   scp_stat_mem #(
      .SECTION_COUNT(SECTION_COUNT)
   ) u_stat_mem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mem_ctl),
      .rd_addr  (mem_rd_addr),
      .wr_addr  (active_ff),
      .wr_sum   (mem_wr_sum),
      .wr_worst (mem_wr_worst),
      .rd_sum   (mem_rd_sum),
      .rd_worst (mem_rd_worst)
   );

   scp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_load  = out_free && ((state_ff == ST_EMIT_SUM) || (state_ff == ST_EMIT_SEC));

   assign csr_pready = 1'b1;
   assign csr_wr_en  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == CSR_REPORT_PERIOD);
   assign csr_prdata = (csr_paddr[2] == CSR_REPORT_PERIOD)
                       ? {{(PDATA_W-PERIOD_W){1'b0}}, period_ff} : '0;

   always_comb begin
      if (req_mode || (int'(req_section) >= SECTION_COUNT)) begin
         req_next_sec = LAST_IDX;
      end else begin
         req_next_sec = IDX_W'(req_section);
      end
   end

   assign pass_len     = stamp_ff - pass_begin_ff;
   assign window       = now_ff - prev_report_ff;
   assign window_short = window < {{(WORD_W-PERIOD_W){1'b0}}, period_ff};

   assign mem_wr_sum   = mem_rd_sum + {{(SUM_W-WORD_W){1'b0}}, span_ff};
   assign mem_wr_worst = (span_ff > mem_rd_worst) ? span_ff : mem_rd_worst;

   always_comb begin
      div_state    = 1'b0;
      div_skip     = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         ST_PPM_DIV: begin
            div_state    = 1'b1;
            div_skip     = (window_ff == '0);
            div_dividend = {{(SUM_W-WORD_W){1'b0}}, pass_total_ff};
            div_divisor  = {{(SUM_W-WORD_W){1'b0}}, window_ff};
         end
         ST_AVG_DIV: begin
            div_state    = 1'b1;
            div_dividend = total_ff;
            div_divisor  = {{(SUM_W-WORD_W){1'b0}}, pass_total_ff};
         end
         ST_SHARE_DIV: begin
            div_state    = 1'b1;
            div_skip     = (total_ff == '0);
            div_dividend = prod_ff;
            div_divisor  = total_ff;
         end
         ST_SEC_AVG_DIV: begin
            div_state    = 1'b1;
            div_dividend = sec_sum_ff;
            div_divisor  = {{(SUM_W-WORD_W){1'b0}}, pass_total_ff};
         end
         default: begin
         end
      endcase
      div_start  = div_state && !started_ff && !div_skip;
      div_finish = div_state && (div_skip || (started_ff && div_done));
   end

   always_comb begin
      state_in          = state_ff;
      mem_ctl.rd_en     = 1'b0;
      mem_ctl.wr_en     = 1'b0;
      mem_ctl.clear_all = 1'b0;
      mem_rd_addr       = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            mem_rd_addr   = active_ff;
            mem_ctl.rd_en = req_accept;
            if (req_accept) begin
               state_in = ST_CHARGE;
            end
         end
         ST_CHARGE: begin
            mem_ctl.wr_en = 1'b1;
            state_in      = mode_ff ? ST_PASS : ST_IDLE;
         end
         ST_PASS: begin
            // A wrapping pass counter takes the report time but emits nothing.
            if (window_short || (pass_total_ff == '1)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_SUM_RD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            state_in = (idx_ff == LAST_IDX) ? ST_PPM_DIV : ST_SUM_RD;
         end
         ST_PPM_DIV: begin
            if (div_finish) begin
               state_in = ST_AVG_DIV;
            end
         end
         ST_AVG_DIV: begin
            if (div_finish) begin
               state_in = ST_EMIT_SUM;
            end
         end
         ST_EMIT_SUM: begin
            if (out_free) begin
               state_in = ST_SEC_RD;
            end
         end
         ST_SEC_RD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = ST_MUL_A;
         end
         ST_MUL_A: begin
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            state_in = ST_SHARE_DIV;
         end
         ST_SHARE_DIV: begin
            if (div_finish) begin
               state_in = ST_SEC_AVG_DIV;
            end
         end
         ST_SEC_AVG_DIV: begin
            if (div_finish) begin
               state_in = ST_EMIT_SEC;
            end
         end
         ST_EMIT_SEC: begin
            if (out_free) begin
               if (idx_ff == LAST_IDX) begin
                  mem_ctl.clear_all = 1'b1;
                  state_in          = ST_IDLE;
               end else begin
                  state_in = ST_SEC_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         started_ff     <= 1'b0;
         idx_ff         <= '0;
         active_ff      <= LAST_IDX;
         prev_mark_ff   <= '0;
         pass_begin_ff  <= '0;
         pass_total_ff  <= '0;
         worst_pass_ff  <= '0;
         prev_report_ff <= '0;
         period_ff      <= REPORT_PERIOD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            period_ff <= csr_pwdata[PERIOD_W-1:0];
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (div_start) begin
            started_ff <= 1'b1;
         end else if (div_finish) begin
            started_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CHARGE: begin
               prev_mark_ff <= stamp_ff;
               active_ff    <= next_sec_ff;
            end
            ST_PASS: begin
               pass_begin_ff <= stamp_ff;
               if ((pass_len > worst_pass_ff) && (pass_total_ff != '0)) begin
                  worst_pass_ff <= pass_len;
               end
               pass_total_ff <= pass_total_ff + 1'b1;
               if (!window_short) begin
                  prev_report_ff <= now_ff;
               end
               idx_ff <= '0;
            end
            ST_SUM_ACC: begin
               if (idx_ff != LAST_IDX) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_EMIT_SUM: begin
               if (out_free) begin
                  idx_ff <= '0;
               end
            end
            ST_EMIT_SEC: begin
               if (out_free) begin
                  if (idx_ff == LAST_IDX) begin
                     pass_total_ff <= '0;
                     worst_pass_ff <= '0;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff     <= req_mode;
         stamp_ff    <= req_cycle_stamp;
         now_ff      <= req_now_ms;
         next_sec_ff <= req_next_sec;
         span_ff     <= req_cycle_stamp - prev_mark_ff;
      end
      unique case (state_ff)
         ST_PASS: begin
            window_ff <= window;
            total_ff  <= '0;
         end
         ST_SUM_ACC: begin
            total_ff <= total_ff + mem_rd_sum;
         end
         ST_PPM_DIV: begin
            if (div_finish) begin
               ppm_ff <= div_skip ? '0 : div_quotient[WORD_W-1:0];
            end
         end
         ST_AVG_DIV: begin
            if (div_finish) begin
               avg_ff <= div_quotient[WORD_W-1:0];
            end
         end
         ST_EMIT_SUM: begin
            if (out_free) begin
               rsp_is_section_ff      <= 1'b0;
               rsp_section_index_ff   <= '0;
               rsp_passes_ff          <= pass_total_ff;
               rsp_passes_per_ms_ff   <= ppm_ff;
               rsp_average_cycles_ff  <= avg_ff;
               rsp_worst_cycles_ff    <= worst_pass_ff;
               rsp_share_per_mille_ff <= '0;
               rsp_last_ff            <= 1'b0;
            end
         end
         ST_MUL_A: begin
            // Times 1000 as 1024 - 32 + 8, split over the states ST_MUL_A and ST_MUL_B.
            sec_sum_ff   <= mem_rd_sum;
            sec_worst_ff <= mem_rd_worst;
            prod_ff      <= (mem_rd_sum << 10) - (mem_rd_sum << 5);
         end
         ST_MUL_B: begin
            prod_ff <= prod_ff + (sec_sum_ff << 3);
         end
         ST_SHARE_DIV: begin
            if (div_finish) begin
               if (div_skip) begin
                  share_ff <= '0;
               end else if (div_quotient[WORD_W-1:0] > {{(WORD_W-SHARE_W){1'b0}}, SHARE_MAX}) begin
                  share_ff <= SHARE_MAX;
               end else begin
                  share_ff <= div_quotient[SHARE_W-1:0];
               end
            end
         end
         ST_SEC_AVG_DIV: begin
            if (div_finish) begin
               avg_ff <= div_quotient[WORD_W-1:0];
            end
         end
         ST_EMIT_SEC: begin
            if (out_free) begin
               rsp_is_section_ff      <= 1'b1;
               rsp_section_index_ff   <= SECTION_W'(idx_ff);
               rsp_passes_ff          <= '0;
               rsp_passes_per_ms_ff   <= '0;
               rsp_average_cycles_ff  <= avg_ff;
               rsp_worst_cycles_ff    <= sec_worst_ff;
               rsp_share_per_mille_ff <= share_ff;
               rsp_last_ff            <= (idx_ff == LAST_IDX);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_section      = rsp_is_section_ff;
   assign rsp_section_index   = rsp_section_index_ff;
   assign rsp_passes          = rsp_passes_ff;
   assign rsp_passes_per_ms   = rsp_passes_per_ms_ff;
   assign rsp_average_cycles  = rsp_average_cycles_ff;
   assign rsp_worst_cycles    = rsp_worst_cycles_ff;
   assign rsp_share_per_mille = rsp_share_per_mille_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ===== rtl/core/scp_checker.sv =====
`include "section_cycle_profiler_defines.svh"

module scp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_is_section,
   input logic [scp_pkg::SECTION_W-1:0] rsp_section_index,
   input logic [scp_pkg::WORD_W-1:0]    rsp_passes,
   input logic [scp_pkg::WORD_W-1:0]    rsp_passes_per_ms,
   input logic [scp_pkg::WORD_W-1:0]    rsp_average_cycles,
   input logic [scp_pkg::WORD_W-1:0]    rsp_worst_cycles,
   input logic [scp_pkg::SHARE_W-1:0]   rsp_share_per_mille,
   input logic                          rsp_last
);
   import scp_pkg::*;

   `SCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_is_section) && $stable(rsp_section_index) && $stable(rsp_average_cycles) && $stable(rsp_worst_cycles) && $stable(rsp_last), "stalled response transaction changed")
   `SCP_ASSERT_SAME(a_summary_shape, clock, reset, rsp_valid && !rsp_is_section, (rsp_section_index == '0) && (rsp_share_per_mille == '0) && !rsp_last && (rsp_passes != '0), "malformed summary transaction")
   `SCP_ASSERT_SAME(a_section_shape, clock, reset, rsp_valid && rsp_is_section, (rsp_passes == '0) && (rsp_passes_per_ms == '0) && (rsp_share_per_mille <= SHARE_MAX), "malformed section transaction")
   `SCP_ASSERT_SAME(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_valid, "response valid right after reset")

endmodule

bind section_cycle_profiler scp_checker u_scp_checker (.*);
